// File: src/swc_pkg.sv
package swc_pkg;

  // fixed field widths
  localparam int unsigned SampleW = 12;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned ValueW  = 31;
  localparam int unsigned IndexW  = 5;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned ProdW   = SampleW + 1 + CoefW;

  // coefficient reset, 0.2 in q1.15
  localparam logic signed [CoefW-1:0] CoefReset = 16'sd6554;

  // request kinds
  typedef enum logic {
    ReqSample = 1'b0,
    ReqToggle = 1'b1
  } req_type_e;

  typedef logic [SampleW-1:0]       sample_t;
  typedef logic signed [CoefW-1:0]  coef_t;
  typedef logic signed [ValueW-1:0] value_t;
  typedef logic signed [ProdW-1:0]  prod_t;

endpackage

// File: src/swc_ram.sv
module swc_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/sample_window_convolver_top.sv
// sample window convolver
//
// input channel: start / busy. a request is taken at a clock edge with start
// high and busy low. req_type_i selects a sample or an enable toggle.
// a toggle flips the enable flag and gives no result; a sample taken while
// disabled is dropped. a sample taken while enabled goes into the circular
// window and starts a run of WINDOW+TAPS-1 results, index 0 upward, the last
// one flagged by last_o.
// result channel: result_valid_o marks each result for exactly one cycle;
// the receiver cannot stall it, so the block never waits on the far side.
// config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i,
// always ready; index 0..TAPS-1 writes a q1.15 tap, other indexes are ignored.
// write taps only while busy is low.
// timing: one multiply-accumulate per cycle through the window memory's single
// read port, so a run issues WINDOW*TAPS multiply-accumulates, then drains its
// pipeline; busy stays high until the last result is out, and a new
// request can be taken in the cycle that last result is shown.
// reset: taps go to 0.2, the window reads as zeros, write pointer to zero,
// block disabled. per-entry valid bits stand in for clearing the window ram,
// so no clearing pass is needed.
module sample_window_convolver_top #(
  parameter int unsigned WINDOW = 16,
  parameter int unsigned TAPS   = 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            req_type_i,
  input  logic [swc_pkg::SampleW-1:0]     sample_value_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [swc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [swc_pkg::CoefW-1:0]       cfg_data_i,
  output logic                            result_valid_o,
  output logic [swc_pkg::IndexW-1:0]      result_index_o,
  output logic signed [swc_pkg::ValueW-1:0] conv_value_o,
  output logic                            last_o
);

  import swc_pkg::*;

  localparam int unsigned Count = WINDOW + TAPS - 1;
  localparam int unsigned AW    = $clog2(WINDOW);
  localparam int unsigned NW    = $clog2(Count);
  localparam int unsigned TW    = (TAPS > 1) ? $clog2(TAPS) : 1;

  localparam logic [NW:0] TapsM1  = (NW+1)'(TAPS - 1);
  localparam logic [NW:0] WinM1   = (NW+1)'(WINDOW - 1);
  localparam logic [NW-1:0] LastN = NW'(Count - 1);
  localparam logic [AW:0] WinSize = (AW+1)'(WINDOW);
  localparam logic [AW-1:0] WpMax = AW'(WINDOW - 1);

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  // control state
  state_e          state_q, state_d;
  logic            enabled_q;
  logic [AW-1:0]   wp_q;
  logic [WINDOW-1:0] valid_q;
  logic [NW-1:0]   n_q, n_d;
  logic [AW-1:0]   k_q, k_d;

  // taps
  coef_t coef_q [TAPS];

  // pipeline
  logic            v1_q, first1_q, last1_q, rdv1_q;
  logic [NW-1:0]   n1_q;
  coef_t           coef1_q;
  logic            v2_q, first2_q, last2_q;
  logic [NW-1:0]   n2_q;
  prod_t           prod2_q;
  value_t          acc_q;

  // result registers
  logic            res_valid_q;
  logic [NW-1:0]   res_n_q;
  value_t          res_value_q;
  logic            res_last_q;

  logic            accept;
  logic            take_sample;
  logic [NW:0]     n_ext, n_nx;
  logic [NW:0]     kmin_cur, kmin_nx, kmax_cur;
  logic [NW:0]     tap_ext;
  logic [TW-1:0]   tap_idx;
  logic [AW:0]     addr_sum;
  logic [AW-1:0]   rd_addr;
  logic            k_first, k_last;
  logic [SampleW-1:0] ram_rdata;
  sample_t         samp1;
  prod_t           prod1;
  value_t          acc_sum;

  assign accept      = start && !busy;
  assign take_sample = accept && (req_type_i == ReqSample) && enabled_q;

  // index arithmetic for the current issue slot
  always_comb begin
    n_ext    = {1'b0, n_q};
    n_nx     = n_ext + 1'b1;
    kmin_cur = (n_ext >= TapsM1) ? n_ext - TapsM1 : '0;
    kmin_nx  = (n_nx >= TapsM1) ? n_nx - TapsM1 : '0;
    kmax_cur = (n_ext < WinM1) ? n_ext : WinM1;
    tap_ext  = n_ext - {1'b0, (NW)'(k_q)};
    tap_idx  = TW'(tap_ext);
    k_first  = ({1'b0, (NW)'(k_q)} == kmin_cur);
    k_last   = ({1'b0, (NW)'(k_q)} == kmax_cur);
    // oldest entry sits at the write pointer
    addr_sum = {1'b0, wp_q} + {1'b0, k_q};
    if (addr_sum >= WinSize) begin
      addr_sum = addr_sum - WinSize;
    end
    rd_addr  = addr_sum[AW-1:0];
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    k_d     = k_q;
    case (state_q)
      StIdle: begin
        if (take_sample) begin
          state_d = StRun;
          n_d     = '0;
          k_d     = '0;
        end
      end
      StRun: begin
        if (k_last) begin
          if (n_q == LastN) begin
            state_d = StIdle;
          end else begin
            n_d = n_nx[NW-1:0];
            k_d = AW'(kmin_nx);
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  swc_ram #(
    .Width(SampleW),
    .Depth(WINDOW)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (take_sample),
    .waddr_i(wp_q),
    .wdata_i(sample_value_i),
    .re_i   (state_q == StRun),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // stage 1: ram data back, multiply
  assign samp1 = rdv1_q ? ram_rdata : '0;
  assign prod1 = $signed({1'b0, samp1}) * coef1_q;

  // stage 2: accumulate, restart on the first product of each output
  assign acc_sum = (first2_q ? value_t'(0) : acc_q) + ValueW'(prod2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      enabled_q   <= 1'b0;
      wp_q        <= '0;
      valid_q     <= '0;
      n_q         <= '0;
      k_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < TAPS; i++) begin
        coef_q[i] <= CoefReset;
      end
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      k_q     <= k_d;

      if (cfg_valid_i && (32'(cfg_index_i) < TAPS)) begin
        coef_q[TW'(cfg_index_i)] <= cfg_data_i;
      end

      if (accept && (req_type_i == ReqToggle)) begin
        enabled_q <= !enabled_q;
      end
      if (take_sample) begin
        valid_q[wp_q] <= 1'b1;
        wp_q          <= (wp_q == WpMax) ? '0 : wp_q + 1'b1;
      end

      v1_q        <= (state_q == StRun);
      v2_q        <= v1_q;
      res_valid_q <= v2_q && last2_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    first1_q <= k_first;
    last1_q  <= k_last;
    n1_q     <= n_q;
    rdv1_q   <= valid_q[rd_addr];
    coef1_q  <= coef_q[tap_idx];

    first2_q <= first1_q;
    last2_q  <= last1_q;
    n2_q     <= n1_q;
    prod2_q  <= prod1;

    if (v2_q) begin
      acc_q <= acc_sum;
    end
    if (v2_q && last2_q) begin
      res_n_q     <= n2_q;
      res_value_q <= acc_sum;
      res_last_q  <= (n2_q == LastN);
    end
  end

  assign busy           = (state_q == StRun) || v1_q || v2_q;
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_valid_q;
  assign result_index_o = IndexW'(res_n_q);
  assign conv_value_o   = res_value_q;
  assign last_o         = res_valid_q && res_last_q;

`ifndef SYNTHESIS
  // no request is taken during a run, so the window pointer holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> $stable(wp_q))
    else $error("write pointer moved during a run");

  // every result comes from a completed output sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(v2_q && last2_q))
    else $error("result without a finished sum");

  // tap index stays within the tap set while issuing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (tap_ext < (NW+1)'(TAPS)))
    else $error("tap index out of range");

  // the final result of a run ends the busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> !busy)
    else $error("run still busy after last result");
`endif

endmodule
